[hdl/stb_pkg.sv]
// Shared types and constants for the software timer bank.
// Used by every module of the block but stb_ram; depends on nothing else.
package stb_pkg;

  // Default sizes of the bank.
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int TICK_WIDTH_DEF = 32;

  // Fixed field widths of the stream words.
  localparam int SLOT_W      = 4;
  localparam int PERIOD_W    = 32;
  localparam int NOW_W       = 32;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // At most this many fired results are reported for one tick.
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_ACK = 2'd0,
    KIND_REM_ACK = 2'd1,
    KIND_NO_FIRE = 2'd2,
    KIND_FIRED   = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input word is taken this cycle
    logic ack;     // deliver the add or remove acknowledge
    logic scan;    // step the slot scan
    logic fin;     // deliver the closing result of a tick
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic scan_done;  // every slot has been visited
  } dp_sts_t;

endpackage

[hdl/stb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the per-slot period and expiry store.
module stb_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/stb_ctrl.sv]
// Controller state machine of the software timer bank.
// Depends on stb_pkg for the command and status structs and the mode codes.
module stb_ctrl import stb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  input  mode_e   s_mode_i,
  output logic    s_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACK  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    s_ready_o  = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
        if (s_valid_i) begin
          case (s_mode_i)
            MODE_TICK:   state_d = ST_SCAN;
            MODE_ADD:    state_d = ST_ACK;
            MODE_REMOVE: state_d = ST_ACK;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACK: begin
        cmd_o.ack = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/stb_dp.sv]
// Datapath of the software timer bank: tick counter, slot flags, slot store,
// scan pipeline and output register. Depends on stb_pkg and stb_ram.
module stb_dp import stb_pkg::*; #(
  parameter int NumSlots  = NUM_SLOTS_DEF,
  parameter int TickWidth = TICK_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  mode_e               s_mode_i,
  input  logic [SLOT_W-1:0]   s_slot_i,
  input  logic [PERIOD_W-1:0] s_period_i,
  input  logic                s_repeat_i,
  input  logic                m_ready_i,
  output logic                m_valid_o,
  output kind_e               m_kind_o,
  output logic [SLOT_W-1:0]   m_slot_o,
  output logic                m_sched_o,
  output logic [NOW_W-1:0]    m_now_o,
  output logic                m_last_o
);

  localparam int IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int CntW = $clog2(NumSlots + 1);
  localparam int RamW = 2 * TickWidth;

  logic [TickWidth-1:0] tick_q;
  logic [NumSlots-1:0]  active_q, repeat_q;
  mode_e                mode_q;

  logic [CntW-1:0]      idx_q;
  logic                 ev_valid_q;
  logic [IdxW-1:0]      ev_idx_q;
  logic                 pend_valid_q;
  logic [IdxW-1:0]      pend_idx_q;
  logic [RES_CNT_W-1:0] res_cnt_q;

  logic                 m_valid_q;
  kind_e                m_kind_q;
  logic [SLOT_W-1:0]    m_slot_q;
  logic                 m_sched_q;
  logic [NOW_W-1:0]     m_now_q;
  logic                 m_last_q;

  logic                 out_free, slot_ok, add_now;
  logic [IdxW-1:0]      in_idx;
  logic [TickWidth-1:0] in_period, ev_period, ev_expiry;
  logic                 ev_fire, ev_report, push_pend, stall, scan_step, issue;
  logic                 push_ack, push_fin;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [RamW-1:0]      ram_wdata, ram_rdata;

  assign out_free  = !m_valid_q || m_ready_i;
  assign slot_ok   = (int'(s_slot_i) < NumSlots);
  assign in_idx    = IdxW'(s_slot_i);
  assign in_period = TickWidth'(s_period_i);
  assign add_now   = cmd_i.accept && (s_mode_i == MODE_ADD) && slot_ok;

  assign ev_period = ram_rdata[RamW-1:TickWidth];
  assign ev_expiry = ram_rdata[TickWidth-1:0];

  // A slot fires when it is armed and its expiry has been reached.
  assign ev_fire   = ev_valid_q && active_q[ev_idx_q] && (ev_expiry <= tick_q);
  assign ev_report = (res_cnt_q < RES_CNT_W'(MAX_RESULTS));
  // The held fire goes out only once a later one proves it is not the last.
  assign push_pend = ev_fire && ev_report && pend_valid_q;
  assign stall     = push_pend && !out_free;
  assign scan_step = cmd_i.scan && !stall;
  assign issue     = scan_step && (idx_q < CntW'(NumSlots));

  assign push_ack  = cmd_i.ack && out_free;
  assign push_fin  = cmd_i.fin && out_free;

  assign sts_o.out_free  = out_free;
  assign sts_o.scan_done = (idx_q == CntW'(NumSlots)) && !ev_valid_q;

  always_comb begin
    ram_we    = add_now || (scan_step && ev_fire && repeat_q[ev_idx_q]);
    ram_waddr = ev_idx_q;
    ram_wdata = {ev_period, tick_q + ev_period};
    if (cmd_i.accept) begin
      ram_waddr = in_idx;
      ram_wdata = {in_period, tick_q + in_period};
    end
  end

  stb_ram #(
    .Width (RamW),
    .Depth (NumSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      active_q     <= '0;
      repeat_q     <= '0;
      mode_q       <= MODE_TICK;
      idx_q        <= '0;
      ev_valid_q   <= 1'b0;
      ev_idx_q     <= '0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
      res_cnt_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        mode_q <= s_mode_i;
        case (s_mode_i)
          MODE_TICK: begin
            tick_q       <= tick_q + TickWidth'(1);
            idx_q        <= '0;
            ev_valid_q   <= 1'b0;
            pend_valid_q <= 1'b0;
            res_cnt_q    <= '0;
          end
          MODE_ADD: begin
            if (slot_ok) begin
              active_q[in_idx] <= 1'b1;
              repeat_q[in_idx] <= s_repeat_i;
            end
          end
          MODE_REMOVE: begin
            if (slot_ok) begin
              active_q[in_idx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (scan_step) begin
        if (ev_fire && !repeat_q[ev_idx_q]) begin
          active_q[ev_idx_q] <= 1'b0;
        end
        if (ev_fire && ev_report) begin
          pend_valid_q <= 1'b1;
          pend_idx_q   <= ev_idx_q;
          res_cnt_q    <= res_cnt_q + RES_CNT_W'(1);
        end
        ev_valid_q <= issue;
        if (issue) begin
          ev_idx_q <= idx_q[IdxW-1:0];
          idx_q    <= idx_q + CntW'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (push_ack || push_fin || (scan_step && push_pend)) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ack || push_fin || (scan_step && push_pend)) begin
      m_now_q <= NOW_W'(tick_q);
    end
    if (push_ack) begin
      m_kind_q  <= (mode_q == MODE_ADD) ? KIND_ADD_ACK : KIND_REM_ACK;
      m_slot_q  <= '0;
      m_sched_q <= 1'b0;
      m_last_q  <= 1'b1;
    end else if (scan_step && push_pend) begin
      m_kind_q  <= KIND_FIRED;
      m_slot_q  <= SLOT_W'(pend_idx_q);
      m_sched_q <= 1'b1;
      m_last_q  <= 1'b0;
    end else if (push_fin) begin
      m_kind_q  <= pend_valid_q ? KIND_FIRED : KIND_NO_FIRE;
      m_slot_q  <= pend_valid_q ? SLOT_W'(pend_idx_q) : '0;
      m_sched_q <= pend_valid_q;
      m_last_q  <= 1'b1;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_kind_o  = m_kind_q;
  assign m_slot_o  = m_slot_q;
  assign m_sched_o = m_sched_q;
  assign m_now_o   = m_now_q;
  assign m_last_o  = m_last_q;

endmodule

[hdl/software_timer_bank_top.sv]
// Top level of the software timer bank: stream ports, word packing, and
// the controller and datapath instances. Depends on stb_pkg, stb_ctrl, stb_dp.
//
// The block keeps NumSlots timer slots and a free-running tick counter of
// TickWidth bits. Commands arrive on the slave stream; tuser carries the mode
// (tick, add, remove, or an ignored code). An add arms or restarts a slot at
// the current tick plus its period, one-shot or repeating; a remove disarms it.
// Each add or remove returns one acknowledge word.
// A tick advances the counter and then visits every slot, one per cycle
// while no fired word waits on a full output register, from a dual-ported
// slot store with registered read. Its closing word leaves once the scan is
// done, and the next command can be taken once that word has entered the
// output register. Every expired slot yields a fired word (up to 16 per tick),
// the last one carrying tlast; a tick with no expiry yields a single no-fire
// word. One command is worked on at a time; tready is high only while the
// controller waits for a new word. The result sits in an output register, so a
// stalled receiver just holds the scan on the next fire; no word is lost.
// Reset clears the counter and all slot flags; the slot store itself needs
// no clearing because a slot's period and expiry are used only once armed.
module software_timer_bank_top import stb_pkg::*; #(
  parameter int NumSlots  = NUM_SLOTS_DEF,
  parameter int TickWidth = TICK_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [3:0] slot, [35:4] period, [36] repeat_req, [39:37] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] mode
  input  logic [MODE_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [3:0] fired_slot, [4] sched_flag, [36:5] now_tick, [39:37] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] kind
  output logic [KIND_W-1:0]      m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  mode_e             s_mode;
  kind_e             m_kind;
  logic [SLOT_W-1:0] m_slot;
  logic              m_sched;
  logic [NOW_W-1:0]  m_now;

  assign s_mode = mode_e'(s_axis_tuser_i);

  stb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_mode_i  (s_mode),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  stb_dp #(
    .NumSlots  (NumSlots),
    .TickWidth (TickWidth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_mode_i   (s_mode),
    .s_slot_i   (s_axis_tdata_i[SLOT_W-1:0]),
    .s_period_i (s_axis_tdata_i[SLOT_W+PERIOD_W-1:SLOT_W]),
    .s_repeat_i (s_axis_tdata_i[SLOT_W+PERIOD_W]),
    .m_ready_i  (m_axis_tready_i),
    .m_valid_o  (m_axis_tvalid_o),
    .m_kind_o   (m_kind),
    .m_slot_o   (m_slot),
    .m_sched_o  (m_sched),
    .m_now_o    (m_now),
    .m_last_o   (m_axis_tlast_o)
  );

  // Pack the result word, lowest field first, zero fill to whole bytes.
  assign m_axis_tdata_o = {
    (OUT_TDATA_W - SLOT_W - 1 - NOW_W)'(0), m_now, m_sched, m_slot
  };
  assign m_axis_tuser_o = m_kind;

endmodule

[hdl/stb_checker.sv]
// Port-level checks for the software timer bank, bound to the top level.
// Depends on stb_pkg for the result kind codes.
module stb_checker import stb_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [MODE_W-1:0]      s_axis_tuser_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [KIND_W-1:0]      m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  // The schedule flag is set exactly on fired words.
  a_sched_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[SLOT_W] == (m_axis_tuser_o == KIND_FIRED)))
    else $error("schedule flag does not match the result kind");

  // Acknowledges and no-fire words always close their command.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != KIND_FIRED)) |-> m_axis_tlast_o)
    else $error("single result word without tlast");

  // Only fired words name a slot.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != KIND_FIRED)) |->
      (m_axis_tdata_o[SLOT_W-1:0] == '0))
    else $error("non-fired word carries a slot number");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("stalled result word changed");

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (.*);

[tb/stb_fire_check.sv]
// Timer bank checker: watches both streams of software_timer_bank_top, predicts
// every result word from the accepted commands and compares them in order.
// Depends on stb_pkg for the field widths and the mode and kind codes.
module stb_fire_check import stb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [MODE_W-1:0]      s_axis_tuser_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic [KIND_W-1:0]      m_axis_tuser_i,
  input  logic                   m_axis_tlast_i,
  output int                     mismatch_count_o,
  output int                     events_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic              sched;
    logic [NOW_W-1:0]  now;
    logic              last;
  } timer_event_t;

  // Predicted state of the bank.
  logic [NOW_W-1:0]         tick_now;
  logic [NUM_SLOTS_DEF-1:0] armed;
  logic [NUM_SLOTS_DEF-1:0] periodic;
  logic [PERIOD_W-1:0]      reload [NUM_SLOTS_DEF];
  logic [NOW_W-1:0]         due_at [NUM_SLOTS_DEF];

  timer_event_t due_events [$];
  timer_event_t want;
  timer_event_t got;
  logic [2:0]   got_pad;
  int           mismatches;

  function automatic timer_event_t make_event(kind_e kind, logic [SLOT_W-1:0] slot,
                                              logic sched, logic [NOW_W-1:0] now,
                                              logic last);
    timer_event_t ev;
    ev.kind  = kind;
    ev.slot  = slot;
    ev.sched = sched;
    ev.now   = now;
    ev.last  = last;
    return ev;
  endfunction

  // Applies one accepted command to the predicted bank and queues its words.
  task automatic predict_timer_events(input mode_e mode, input logic [SLOT_W-1:0] slot,
                                      input logic [PERIOD_W-1:0] period,
                                      input logic rep);
    int                fired;
    logic [SLOT_W-1:0] fired_slots [MAX_RESULTS];
    fired = 0;
    case (mode)
      MODE_ADD: begin
        reload[slot]   = period;
        due_at[slot]   = tick_now + period;
        periodic[slot] = rep;
        armed[slot]    = 1'b1;
        due_events.push_back(make_event(KIND_ADD_ACK, '0, 1'b0, tick_now, 1'b1));
      end
      MODE_REMOVE: begin
        armed[slot] = 1'b0;
        due_events.push_back(make_event(KIND_REM_ACK, '0, 1'b0, tick_now, 1'b1));
      end
      MODE_TICK: begin
        tick_now = tick_now + 1'b1;
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
          if (armed[i] && due_at[i] <= tick_now) begin
            if (periodic[i]) begin
              due_at[i] = tick_now + reload[i];
            end else begin
              armed[i] = 1'b0;
            end
            if (fired < MAX_RESULTS) begin
              fired_slots[fired] = SLOT_W'(i);
              fired++;
            end
          end
        end
        if (fired == 0) begin
          due_events.push_back(make_event(KIND_NO_FIRE, '0, 1'b0, tick_now, 1'b1));
        end
        for (int j = 0; j < fired; j++) begin
          due_events.push_back(make_event(KIND_FIRED, fired_slots[j], 1'b1, tick_now,
                                          j == fired - 1));
        end
      end
      default: ;  // the unused mode changes nothing and answers nothing
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_now   = '0;
      armed      = '0;
      periodic   = '0;
      mismatches = 0;
      due_events.delete();
      mismatch_count_o <= 0;
      events_due_o     <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_timer_events(mode_e'(s_axis_tuser_i), s_axis_tdata_i[3:0],
                             s_axis_tdata_i[35:4], s_axis_tdata_i[36]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got     = make_event(kind_e'(m_axis_tuser_i), m_axis_tdata_i[3:0],
                             m_axis_tdata_i[4], m_axis_tdata_i[36:5], m_axis_tlast_i);
        got_pad = m_axis_tdata_i[39:37];
        if (due_events.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected word kind %0d slot %0d sched %0b now %0d last %0b",
                     $realtime, got.kind, got.slot, got.sched, got.now, got.last);
          end
        end else begin
          want = due_events.pop_front();
          if (got.kind != want.kind || got.slot != want.slot || got.sched != want.sched ||
              got.now != want.now || got.last != want.last || got_pad != 3'b000) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: word mismatch", $realtime);
              $display("  expected kind %0d slot %0d sched %0b now %0d last %0b pad 0",
                       want.kind, want.slot, want.sched, want.now, want.last);
              $display("  actual   kind %0d slot %0d sched %0b now %0d last %0b pad %0d",
                       got.kind, got.slot, got.sched, got.now, got.last, got_pad);
            end
          end
        end
      end
      mismatch_count_o <= mismatches;
      events_due_o     <= due_events.size();
    end
  end

endmodule

[tb/software_timer_bank_top_test.sv]
// Top of the timer bank testbench: clock, reset, command stimulus and the
// result sink. Depends on stb_pkg, software_timer_bank_top and stb_fire_check.
module software_timer_bank_top_test;
  import stb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Random commands after the directed part; the unused mode is not counted.
  localparam int RANDOM_COMMANDS = 160;
  // Allow more than twice the span of a full tick scan after the last
  // expected word so that any stray word still shows up.
  localparam int DRAIN_CYCLES = 2 * (NUM_SLOTS_DEF + 3) + 16;
  // Longest legal quiet stretch: a sender gap, a full scan and a receiver
  // stall back to back stay well under this limit.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_IDLE = 13;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Slave side of the block, driven by the stimulus process.
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data = '0;   // [3:0] slot, [35:4] period, [36] repeat_req
  logic [MODE_W-1:0]      s_user = MODE_TICK;  // [1:0] mode

  // Master side of the block, accepted by the sink process.
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;        // [3:0] fired_slot, [4] sched_flag, [36:5] now_tick
  logic [KIND_W-1:0]      m_user;        // [1:0] kind
  logic                   m_last;

  int mismatches;
  int events_due;
  int quiet_cycles = 0;
  // While set, neither side idles, so the block runs back to back.
  bit steady = 1'b0;

  always #5 clk_i = ~clk_i;

  software_timer_bank_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  stb_fire_check fire_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .s_axis_tuser_i   (s_user),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tuser_i   (m_user),
    .m_axis_tlast_i   (m_last),
    .mismatch_count_o (mismatches),
    .events_due_o     (events_due)
  );

  // Number of idle cycles a side waits before its next word.
  function automatic int draw_idle();
    return steady ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Periods are mostly short so that slots expire often. Some sit just
  // below the wrap point, so the expiry lands behind the counter and the
  // plain unsigned compare decides; the rest spread over all 32 bits.
  function automatic logic [PERIOD_W-1:0] draw_period();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return PERIOD_W'($urandom_range(0, 6));
      6:                return 32'hFFFF_FFFF - PERIOD_W'($urandom_range(0, 40));
      7:                return PERIOD_W'($urandom_range(7, 60));
      default:          return $urandom();
    endcase
  endfunction

  // Presents one command word after a random gap and holds it until the
  // block takes it. The task returns in the time step of the accepting edge,
  // so the next call may keep tvalid high without lowering it first.
  task automatic send_command(input mode_e mode, input logic [SLOT_W-1:0] slot,
                              input logic [PERIOD_W-1:0] period, input logic rep);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {3'b000, rep, period, slot};
    s_user  <= mode;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // A tick whose unused fields carry random values.
  task automatic send_tick();
    send_command(MODE_TICK, SLOT_W'($urandom_range(0, 15)), $urandom(),
                 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int commands;
    int next_phase;
    int pick;
    int burst;
    bit sweep;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The counter starts at zero after reset.
    send_tick();                                   // nothing armed: no-fire word
    send_command(MODE_ADD, 4'd0, 32'd0, 1'b0);     // one-shot due at once
    send_tick();                                   // slot 0 fires and is disarmed
    send_tick();                                   // nothing left to fire
    send_command(MODE_ADD, 4'd15, 32'd0, 1'b1);    // periodic with zero period
    send_command(MODE_ADD, 4'd3, 32'd1, 1'b1);
    send_tick();                                   // slots 3 and 15 fire in slot order
    send_tick();                                   // zero period fires once per tick only
    send_command(MODE_REMOVE, 4'd15, 32'd0, 1'b0);
    send_tick();
    // The sum wraps, so the expiry falls just behind the counter.
    send_command(MODE_ADD, 4'd7, 32'hFFFF_FFFF, 1'b0);
    send_tick();
    send_command(MODE_ADD, 4'd5, 32'd3, 1'b1);
    send_command(MODE_ADD, 4'd5, 32'd1, 1'b0);     // restart of an active slot
    send_tick();
    send_command(MODE_REMOVE, 4'd3, 32'd0, 1'b0);
    send_command(MODE_REMOVE, 4'd9, 32'd0, 1'b0);  // removing an idle slot is still acked
    send_command(MODE_ADD, 4'd10, 32'h8000_0000, 1'b1);
    send_command(MODE_NONE, 4'd6, 32'h5A5A_A5A5, 1'b1);  // ignored, no word back
    send_tick();
    send_command(MODE_REMOVE, 4'd10, 32'd0, 1'b0);

    // Random part. Each phase picks at random between random idling and none.
    // Now and then a burst arms many slots with short periods and ticks a
    // few times, which gives ticks with many fired words; a sweep arms every
    // slot so that all of them expire within those ticks.
    commands   = 0;
    next_phase = 0;
    while (commands < RANDOM_COMMANDS) begin
      if (commands >= next_phase) begin
        steady = ($urandom_range(0, 3) == 0);
        next_phase += 30;
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        sweep = ($urandom_range(0, 2) == 0);
        burst = sweep ? NUM_SLOTS_DEF : $urandom_range(4, 12);
        for (int k = 0; k < burst; k++) begin
          send_command(MODE_ADD, sweep ? SLOT_W'(k) : SLOT_W'($urandom_range(0, 15)),
                       PERIOD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        repeat (3) send_tick();
        commands += burst + 3;
      end else if (pick < 10) begin
        send_tick();
        commands++;
      end else if (pick < 16) begin
        send_command(MODE_ADD, SLOT_W'($urandom_range(0, 15)), draw_period(),
                     1'($urandom_range(0, 1)));
        commands++;
      end else if (pick < 19) begin
        send_command(MODE_REMOVE, SLOT_W'($urandom_range(0, 15)), $urandom(),
                     1'($urandom_range(0, 1)));
        commands++;
      end else begin
        send_command(MODE_NONE, SLOT_W'($urandom_range(0, 15)), $urandom(),
                     1'($urandom_range(0, 1)));
      end
    end
    s_valid <= 1'b0;

    // The checker's count is registered and updates in the cycle after the accepting edge.
    @(posedge clk_i);
    while (events_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && events_due == 0) begin
      $display("software_timer_bank_top_test passed");
    end else begin
      $display("software_timer_bank_top_test failed");
    end
    $finish;
  end

  // Result sink: stalls a random number of cycles before each word, then
  // holds tready high until a word is taken.
  initial begin : sink
    int stall;
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end

  // Watchdog: a run that stops moving on both streams is a failure.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("software_timer_bank_top_test failed");
      $finish;
    end
  end

endmodule
